>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// Each macro wraps one concurrent assertion that reports through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define ASSERT_CLK(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

>>> hdl/seht_pkg.sv
// ----------------------------------------------------------------------------
// seht_pkg
// Shared constants, codes and types of the scope edge trigger.
// ----------------------------------------------------------------------------
package seht_pkg;

  // Capture geometry.
  localparam int CAPTURE_DEPTH = 1024;
  localparam int WINDOW        = 8;
  localparam int SAMPLE_BITS   = 12;
  localparam int COUNT_BITS    = $clog2(CAPTURE_DEPTH);
  localparam int INDEX_BITS    = 10;

  // Register widths.
  localparam int LEVEL_BITS   = 12;
  localparam int MODE_BITS    = 2;
  localparam int HYST_BITS    = 10;
  localparam int TIMEOUT_BITS = 8;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_INDEX_BITS = 2;

  // Width that holds level plus or minus hysteresis and any sample, with sign.
  localparam int THR_BITS =
    ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 2;

  // Missed capture counter.
  localparam int MISS_BITS = 8;
  localparam logic [MISS_BITS-1:0] MISS_MAX = '1;

  // Register reset values.
  localparam logic [LEVEL_BITS-1:0]   LEVEL_RESET   = LEVEL_BITS'(2000);
  localparam logic [HYST_BITS-1:0]    HYST_RESET    = HYST_BITS'(50);
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(10);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEVEL   = 2'd0,
    CFG_MODE    = 2'd1,
    CFG_HYST    = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_index_t;

  // Trigger modes; the unused code behaves as normal.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_AUTO   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_NONE   = 2'd2
  } trig_mode_t;

  // Edge status of the current capture, including the item being examined.
  typedef struct packed {
    logic                  seen;
    logic [INDEX_BITS-1:0] index;
  } edge_info_t;

endpackage

>>> hdl/seht_window.sv
// ----------------------------------------------------------------------------
// seht_window
// Sample history, sample index and qualified rising edge search.
// ----------------------------------------------------------------------------
module seht_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [seht_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic                                last,
  input  logic [seht_pkg::LEVEL_BITS-1:0]     level,
  input  logic [seht_pkg::HYST_BITS-1:0]      hyst,
  output seht_pkg::edge_info_t                edge_info
);

  localparam int WIN       = seht_pkg::WINDOW;
  localparam int CNT_BITS  = seht_pkg::COUNT_BITS;
  localparam int THR       = seht_pkg::THR_BITS;
  localparam int BELOW_BITS = $clog2(WIN + 1);
  localparam logic [CNT_BITS-1:0] CNT_MAX   = CNT_BITS'(seht_pkg::CAPTURE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FIRST = CNT_BITS'(WIN + 1);
  localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(seht_pkg::CAPTURE_DEPTH / 2);

  logic [seht_pkg::SAMPLE_BITS-1:0] history [WIN];
  logic [CNT_BITS-1:0]              sample_count;
  logic                             edge_seen;
  logic [seht_pkg::INDEX_BITS-1:0]  edge_index;

  logic [THR-1:0]        thr_high;
  logic [THR-1:0]        thr_low;
  logic                  low_negative;
  logic [WIN-1:0]        below_flags;
  logic [WIN-1:0]        at_level_flags;
  logic [BELOW_BITS-1:0] below_num;
  logic                  in_range;
  logic                  candidate;
  logic [CNT_BITS-1:0]   back_step;
  logic [CNT_BITS-1:0]   pick_index;

  // Thresholds around the level.
  assign thr_high     = THR'(level) + THR'(hyst);
  assign thr_low      = THR'(level) - THR'(hyst);
  assign low_negative = THR'(hyst) > THR'(level);

  // Per-tap compares against the low threshold and the level.
  always_comb begin
    for (int w = 0; w < WIN; w++) begin
      below_flags[w]    = !low_negative && (THR'(history[w]) < thr_low);
      at_level_flags[w] = THR'(history[w]) <= THR'(level);
    end
  end

  assign below_num = BELOW_BITS'($countones(below_flags));
  assign in_range  = (sample_count >= CNT_FIRST) && (sample_count < CNT_LIMIT);
  assign candidate = !edge_seen && in_range && (THR'(sample) > thr_high) &&
                     (below_num >= BELOW_BITS'(WIN / 2));

  // Nearest earlier sample at or below the level; tap 0 is the newest.
  always_comb begin
    back_step = '0;
    for (int w = WIN - 1; w >= 0; w--) begin
      if (at_level_flags[w]) begin
        back_step = CNT_BITS'(w + 1);
      end
    end
  end

  assign pick_index = (back_step == '0) ? '0 : (sample_count - back_step);

  // Edge status after this item, seen by the report stage.
  always_comb begin
    edge_info.seen  = edge_seen || candidate;
    edge_info.index = candidate ? seht_pkg::INDEX_BITS'(pick_index) : edge_index;
  end

  // Capture state: shift and count on ordinary items, clear after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      edge_seen    <= 1'b0;
      edge_index   <= '0;
      for (int w = 0; w < WIN; w++) begin
        history[w] <= '0;
      end
    end else if (advance) begin
      if (last) begin
        sample_count <= '0;
        edge_seen    <= 1'b0;
        edge_index   <= '0;
        for (int w = 0; w < WIN; w++) begin
          history[w] <= '0;
        end
      end else begin
        edge_seen  <= edge_info.seen;
        edge_index <= edge_info.index;
        history[0] <= sample;
        for (int w = 1; w < WIN; w++) begin
          history[w] <= history[w-1];
        end
        if (sample_count < CNT_MAX) begin
          sample_count <= sample_count + 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/seht_report.sv
// ----------------------------------------------------------------------------
// seht_report
// End of capture decision, missed capture counter and result register.
// ----------------------------------------------------------------------------
module seht_report (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 report,
  input  seht_pkg::edge_info_t                 edge_info,
  input  logic [seht_pkg::MODE_BITS-1:0]       mode,
  input  logic [seht_pkg::TIMEOUT_BITS-1:0]    timeout,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 found,
  output logic [seht_pkg::INDEX_BITS-1:0]      trigger_index,
  output logic                                 draw
);

  logic [seht_pkg::MISS_BITS-1:0] missed_count;
  logic [seht_pkg::MISS_BITS-1:0] missed_count_next;
  logic                           found_next;
  logic [seht_pkg::INDEX_BITS-1:0] index_next;
  logic                           draw_next;

  // Decision for the capture that ends with this item.
  always_comb begin
    missed_count_next = missed_count;
    found_next        = 1'b0;
    index_next        = '0;
    draw_next         = 1'b0;
    case (seht_pkg::trig_mode_t'(mode))
      seht_pkg::MODE_NONE: begin
        found_next = 1'b1;
        draw_next  = 1'b1;
      end
      default: begin
        if (edge_info.seen) begin
          missed_count_next = '0;
          found_next        = 1'b1;
          index_next        = edge_info.index;
          draw_next         = 1'b1;
        end else begin
          if (missed_count != seht_pkg::MISS_MAX) begin
            missed_count_next = missed_count + 1'b1;
          end
          draw_next = (seht_pkg::trig_mode_t'(mode) == seht_pkg::MODE_AUTO) &&
                      (missed_count_next > seht_pkg::MISS_BITS'(timeout));
        end
      end
    endcase
  end

  // Missed capture counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      missed_count <= '0;
    end else if (report) begin
      missed_count <= missed_count_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (report) begin
      found         <= found_next;
      trigger_index <= index_next;
      draw          <= draw_next;
    end
  end

endmodule

>>> hdl/scope_edge_trigger_hysteresis_unit.sv
// ----------------------------------------------------------------------------
// scope_edge_trigger_hysteresis_unit
// Rising edge trigger with hysteresis over a stream of ADC capture samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples of one capture arrive in order on the in channel (sample, last)
//   with valid/ready. The item carrying last=1 closes the capture and is
//   itself examined. Only that item produces a result on the out channel
//   (found, trigger_index, draw); other items produce none.
//   The block takes one item per clock while in_ready is high. An accepted
//   item sits in the input register; the result of a closing item is then
//   loaded into the output register, which raises out_valid. The single
//   compare and priority pick stage lies between the input and output
//   registers.
//   If the receiver stalls while a result is pending, ordinary samples keep
//   flowing; only a closing item waits in the input register, which then
//   holds in_ready low until the output register is free.
//   Reset clears the sample history, the sample index, the edge status and
//   the missed capture count, and loads the registers with level 2000,
//   auto mode, hysteresis 50 and timeout 10. The user must write them via
//   cfg_write/cfg_index/cfg_data only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module scope_edge_trigger_hysteresis_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [seht_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [seht_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [seht_pkg::SAMPLE_BITS-1:0]      sample,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  found,
  output logic [seht_pkg::INDEX_BITS-1:0]       trigger_index,
  output logic                                  draw
);

  logic [seht_pkg::LEVEL_BITS-1:0]   trigger_level;
  logic [seht_pkg::MODE_BITS-1:0]    trigger_mode;
  logic [seht_pkg::HYST_BITS-1:0]    hysteresis;
  logic [seht_pkg::TIMEOUT_BITS-1:0] auto_timeout;

  logic                              stage_valid;
  logic [seht_pkg::SAMPLE_BITS-1:0]  stage_sample;
  logic                              stage_last;
  logic                              stage_go;
  logic                              out_free;
  seht_pkg::edge_info_t              edge_info;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level <= seht_pkg::LEVEL_RESET;
      trigger_mode  <= seht_pkg::MODE_AUTO;
      hysteresis    <= seht_pkg::HYST_RESET;
      auto_timeout  <= seht_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (seht_pkg::cfg_index_t'(cfg_index))
        seht_pkg::CFG_LEVEL:   trigger_level <= cfg_data[seht_pkg::LEVEL_BITS-1:0];
        seht_pkg::CFG_MODE:    trigger_mode  <= cfg_data[seht_pkg::MODE_BITS-1:0];
        seht_pkg::CFG_HYST:    hysteresis    <= cfg_data[seht_pkg::HYST_BITS-1:0];
        seht_pkg::CFG_TIMEOUT: auto_timeout  <= cfg_data[seht_pkg::TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: only a closing item needs room in the output register.
  assign out_free = !out_valid || out_ready;
  assign stage_go = stage_valid && (!stage_last || out_free);
  assign in_ready = !stage_valid || stage_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_sample <= sample;
      stage_last   <= last;
    end
  end

  // Edge search over the sample window.
  seht_window u_window (
    .clk       (clk),
    .rst       (rst),
    .advance   (stage_go),
    .sample    (stage_sample),
    .last      (stage_last),
    .level     (trigger_level),
    .hyst      (hysteresis),
    .edge_info (edge_info)
  );

  // End of capture decision and result register.
  seht_report u_report (
    .clk           (clk),
    .rst           (rst),
    .report        (stage_go && stage_last),
    .edge_info     (edge_info),
    .mode          (trigger_mode),
    .timeout       (auto_timeout),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .found         (found),
    .trigger_index (trigger_index),
    .draw          (draw)
  );

endmodule

>>> hdl/seht_checker.sv
// ----------------------------------------------------------------------------
// seht_checker
// Port level checks of the scope edge trigger, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module seht_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cfg_write,
  input logic [seht_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input logic [seht_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [seht_pkg::SAMPLE_BITS-1:0]      sample,
  input logic                                  last,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  found,
  input logic [seht_pkg::INDEX_BITS-1:0]       trigger_index,
  input logic                                  draw
);

  // A stalled result item keeps its contents.
  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(found) && $stable(trigger_index) && $stable(draw), "result item changed while stalled")

  // A capture without an edge reports the start of the buffer.
  `ASSERT_CLK_RST(a_miss_index, clk, rst, out_valid && !found |-> trigger_index == '0, "nonzero index without a trigger")

  // Every triggered capture is drawn.
  `ASSERT_CLK_RST(a_found_draw, clk, rst, out_valid && found |-> draw, "triggered capture not drawn")

  // No result item is pending right after reset.
  `ASSERT_CLK(a_reset_idle, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind scope_edge_trigger_hysteresis_unit seht_checker u_seht_checker (.*);
